// ===== hw/rtl/sgm_pkg.sv =====
// shared types and constants for the silu gated multiply datapath
// the sigmoid table is built at elaboration from SIGMOID_TABLE_DEPTH
// no dependencies
`default_nettype none

package sgm_pkg;

  localparam int unsigned SIGMOID_TABLE_DEPTH = 256;
  localparam int unsigned IdxW  = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned AddrW = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int unsigned SigW  = 17;
  localparam int unsigned GateW = 16;
  localparam int unsigned UpW   = 16;
  localparam int unsigned ProdW = 24;

  localparam longint unsigned ONE_Q30      = 64'd1 << 30;
  localparam longint unsigned EXP_NEG1_Q30 = 64'd395007543;
  localparam int unsigned     TAYLOR_TERMS = 24;
  localparam logic [SigW-1:0] SIG_ONE      = 17'd65536;

  typedef logic [SIGMOID_TABLE_DEPTH:0][SigW-1:0] sig_rom_t;

  typedef struct packed {
    logic                    valid;
    logic signed [GateW-1:0] gate;
    logic signed [UpW-1:0]   up;
    logic                    row_end;
  } sgm_side_t;

  // shift and subtract quotient, only used while the table is built
  function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem  = rem - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid samples over [-8, 8], Q1.16, exp(-|x|) via truncated taylor series
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t          rom;
    longint unsigned   d;
    longint unsigned   pos;
    longint unsigned   mid;
    longint unsigned   mag;
    longint unsigned   fq;
    longint unsigned   term;
    longint unsigned   r;
    longint unsigned   den;
    longint unsigned   s;
    longint unsigned   ip;
    longint            sum;
    logic              neg;
    rom = '0;
    d   = longint'(SIGMOID_TABLE_DEPTH);
    for (int k = 0; k <= int'(SIGMOID_TABLE_DEPTH); k++) begin
      pos = 16 * longint'(k);
      mid = 8 * d;
      neg = (pos < mid);
      mag = neg ? (mid - pos) : (pos - mid);
      ip  = div_u64(mag, d);
      fq  = div_u64((mag - ip * d) << 30, d);
      sum  = longint'(ONE_Q30);
      term = ONE_Q30;
      for (longint unsigned n = 1; n <= longint'(TAYLOR_TERMS); n++) begin
        term = div_u64((term * fq) >> 30, n);
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = longint'(sum);
      for (longint unsigned n = 0; n < ip; n++) begin
        r = (r * EXP_NEG1_Q30 + (ONE_Q30 >> 1)) >> 30;
      end
      den = ONE_Q30 + r;
      if (neg) begin
        s = div_u64((r << 16) + (den >> 1), den);
      end else begin
        s = div_u64((64'd1 << 46) + (den >> 1), den);
      end
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      rom[k] = s[SigW-1:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SigRom = build_sig_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/sgm_sigmoid.sv =====
// sigmoid of the gate by table lookup and linear interpolation, three stages
// carries the item side band alongside; depends on sgm_pkg
`default_nettype none

module sgm_sigmoid import sgm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sgm_side_t       side_i,
  output sgm_side_t            side_o,
  output logic      [SigW-1:0] sig_o
);

  localparam int unsigned PW = GateW + AddrW;

  // stage 1: table address and fraction
  sgm_side_t        s1_side_q;
  logic [IdxW-1:0]  s1_idx_q, s1_idx_d;
  logic [15:0]      s1_frac_q, s1_frac_d;
  // stage 2: neighboring samples
  sgm_side_t        s2_side_q;
  logic [SigW-1:0]  s2_lo_q, s2_lo_d;
  logic [SigW-1:0]  s2_hi_q, s2_hi_d;
  logic [15:0]      s2_frac_q;
  // stage 3: interpolated sigmoid
  sgm_side_t        s3_side_q;
  logic [SigW-1:0]  s3_sig_q, s3_sig_d;

  logic [PW-1:0]    pos;
  logic [AddrW-1:0] idx_full;
  logic [AddrW-1:0] addr_lo;
  logic [AddrW-1:0] addr_hi;
  logic [SigW-1:0]  diff;
  logic [SigW+16:0] step;

  always_comb begin
    // offset binary of the gate, scaled by the table depth
    pos = PW'({~side_i.gate[GateW-1], side_i.gate[GateW-2:0]}) * PW'(SIGMOID_TABLE_DEPTH);
    idx_full = pos[PW-1:16];
    if (idx_full >= AddrW'(SIGMOID_TABLE_DEPTH)) begin
      s1_idx_d = IdxW'(SIGMOID_TABLE_DEPTH - 1);
    end else begin
      s1_idx_d = idx_full[IdxW-1:0];
    end
    s1_frac_d = pos[15:0];
  end

  always_comb begin
    addr_lo = AddrW'(s1_idx_q);
    addr_hi = AddrW'(s1_idx_q) + AddrW'(1);
    s2_lo_d = SigRom[addr_lo];
    s2_hi_d = SigRom[addr_hi];
  end

  always_comb begin
    diff = (s2_hi_q >= s2_lo_q) ? (s2_hi_q - s2_lo_q) : (s2_lo_q - s2_hi_q);
    step = (SigW+17)'(diff) * (SigW+17)'(s2_frac_q) + (SigW+17)'(32768);
    if (s2_hi_q >= s2_lo_q) begin
      s3_sig_d = s2_lo_q + step[SigW+15:16];
    end else begin
      s3_sig_d = s2_lo_q - step[SigW+15:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_side_q <= '0;
      s2_side_q <= '0;
      s3_side_q <= '0;
    end else begin
      s1_side_q <= side_i;
      s2_side_q <= s1_side_q;
      s3_side_q <= s2_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= s1_idx_d;
    s1_frac_q <= s1_frac_d;
    s2_lo_q   <= s2_lo_d;
    s2_hi_q   <= s2_hi_d;
    s2_frac_q <= s1_frac_q;
    s3_sig_q  <= s3_sig_d;
  end

  assign side_o = s3_side_q;
  assign sig_o  = s3_sig_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_side_q.valid |-> (s3_sig_q <= SIG_ONE))
    else $error("interpolated sigmoid above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_side_q.valid |-> $past(side_i.valid, 3))
    else $error("sigmoid stage valid without an entering item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_side_q.valid |-> (s2_lo_q <= SIG_ONE && s2_hi_q <= SIG_ONE))
    else $error("table sample out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/silu_gated_multiply_top.sv =====
// silu(gate) * up: sigmoid lookup, two multiply stages, round and clamp to Q7.16
// each item passes the sigmoid stages, stages 4 and 5, then the output register
// throughput: one item per cycle, busy_o is never raised
// every stage is a fixed register, results cannot be held off by the receiver
// reset clears all valid bits and the sigmoid side band; other data registers are not reset
`default_nettype none

module silu_gated_multiply_top import sgm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic signed [GateW-1:0] gate_i,
  input  wire logic signed [UpW-1:0]   up_i,
  input  wire logic                    row_end_i,
  output logic                         result_valid_o,
  output logic signed [ProdW-1:0]      product_o,
  output logic                         row_end_out_o
);

  localparam int unsigned SiluW   = GateW + SigW;
  localparam int unsigned WideW   = SiluW + UpW;
  localparam int unsigned Latency = 6;
  localparam logic signed [WideW:0] RoundHalf = (WideW+1)'(1) <<< 23;
  localparam logic signed [WideW:0] ProdMax   = (WideW+1)'(8388607);
  localparam logic signed [WideW:0] ProdMin   = ~ProdMax;

  sgm_side_t side_in;
  sgm_side_t sig_side;
  logic [SigW-1:0] sig;

  // stage 4: silu in Q4.28
  logic                    s4_valid_q;
  logic                    s4_row_end_q;
  logic signed [UpW-1:0]   s4_up_q;
  logic signed [SiluW-1:0] s4_silu_q, s4_silu_d;
  // stage 5: full product
  logic                    s5_valid_q;
  logic                    s5_row_end_q;
  logic signed [WideW-1:0] s5_wide_q, s5_wide_d;
  // output register
  logic                    out_valid_q;
  logic                    out_row_end_q;
  logic signed [ProdW-1:0] out_prod_q, out_prod_d;

  logic signed [WideW:0]   rounded;
  logic signed [WideW:0]   shifted;

  assign busy_o = 1'b0;

  always_comb begin
    side_in.valid   = start_i && !busy_o;
    side_in.gate    = gate_i;
    side_in.up      = up_i;
    side_in.row_end = row_end_i;
  end

  sgm_sigmoid u_sigmoid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_in),
    .side_o (sig_side),
    .sig_o  (sig)
  );

  always_comb begin
    s4_silu_d = SiluW'(sig_side.gate) * SiluW'($signed({1'b0, sig}));
    s5_wide_d = WideW'(s4_silu_q) * WideW'(s4_up_q);
  end

  // round half up, floor shift into Q7.16, then clamp
  always_comb begin
    rounded = {s5_wide_q[WideW-1], s5_wide_q} + RoundHalf;
    shifted = rounded >>> 24;
    if (shifted > ProdMax) begin
      out_prod_d = ProdMax[ProdW-1:0];
    end else if (shifted < ProdMin) begin
      out_prod_d = ProdMin[ProdW-1:0];
    end else begin
      out_prod_d = shifted[ProdW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s4_valid_q  <= sig_side.valid;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_silu_q     <= s4_silu_d;
    s4_up_q       <= sig_side.up;
    s4_row_end_q  <= sig_side.row_end;
    s5_wide_q     <= s5_wide_d;
    s5_row_end_q  <= s4_row_end_q;
    out_prod_q    <= out_prod_d;
    out_row_end_q <= s5_row_end_q;
  end

  assign result_valid_o = out_valid_q;
  assign product_o      = out_prod_q;
  assign row_end_out_o  = out_row_end_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without a matching start transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency result_valid_o)
    else $error("start transfer produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (row_end_out_o == $past(row_end_i, Latency)))
    else $error("row flag out of step with its item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q |-> (shifted <= ProdMax && shifted >= ProdMin))
    else $error("product outside Q7.16 range before clamp");

endmodule

`default_nettype wire

// ===== test/tb_silu_gated_multiply_top.sv =====
// self-checking testbench for silu_gated_multiply_top: random and directed gate/up pairs
// predicts silu(gate) * up in Q7.16 from its own sigmoid table and checks every strobe
// depends on sgm_pkg and silu_gated_multiply_top
`timescale 1ns / 1ps

module tb_silu_gated_multiply_top;
  import sgm_pkg::*;

  localparam longint unsigned OneQ30      = 64'd1 << 30;
  localparam longint unsigned ExpNeg1Q30  = 64'd395007543;
  localparam int              TaylorTerms = 24;
  localparam longint          ProdMax     = 64'sd8388607;
  localparam longint          ProdMin     = -64'sd8388608;
  localparam int              DrainCycles = 12;
  localparam int              CycleLimit  = 200000;
  localparam int              RandomItems = 500;

  typedef struct {
    logic signed [GateW-1:0] gate;
    logic signed [UpW-1:0]   up;
    logic                    row_end;
    int                      idle;
  } gate_up_item_t;

  typedef struct {
    logic signed [ProdW-1:0] product;
    logic                    row_end;
  } swiglu_out_t;

  logic                    clk_i     = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    start_i   = 1'b0;
  logic signed [GateW-1:0] gate_i    = '0;
  logic signed [UpW-1:0]   up_i      = '0;
  logic                    row_end_i = 1'b0;
  logic                    busy_o;
  logic                    result_valid_o;
  logic signed [ProdW-1:0] product_o;
  logic                    row_end_out_o;

  longint unsigned sig_tab [0:SIGMOID_TABLE_DEPTH];
  gate_up_item_t   item_queue[$];
  swiglu_out_t     expected_outputs[$];
  gate_up_item_t   cur;
  logic            holding   = 1'b0;
  int              idle_left = 0;
  int              n_items   = 0;
  int              n_accepted = 0;
  int              n_errors  = 0;
  int              cycles    = 0;

  silu_gated_multiply_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .gate_i         (gate_i),
    .up_i           (up_i),
    .row_end_i      (row_end_i),
    .result_valid_o (result_valid_o),
    .product_o      (product_o),
    .row_end_out_o  (row_end_out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // interpolated sigmoid, gate * sigmoid * up, round half up into Q7.16, clamp
  function automatic logic signed [ProdW-1:0] silu_times_up(logic signed [GateW-1:0] g,
                                                            logic signed [UpW-1:0] u);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned f;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned sig;
    longint          silu;
    longint          prod;
    pos = longint'(longint'(g) + 64'sd32768) * SIGMOID_TABLE_DEPTH;
    idx = pos >> 16;
    f   = pos & 64'hFFFF;
    if (idx >= SIGMOID_TABLE_DEPTH) begin
      idx = SIGMOID_TABLE_DEPTH - 1;
    end
    lo = sig_tab[idx];
    hi = sig_tab[idx + 1];
    if (hi >= lo) begin
      sig = lo + (((hi - lo) * f + 64'd32768) >> 16);
    end else begin
      sig = lo - (((lo - hi) * f + 64'd32768) >> 16);
    end
    silu = longint'(g) * longint'(sig);
    prod = (silu * longint'(u) + 64'sd8388608) >>> 24;
    if (prod > ProdMax) begin
      prod = ProdMax;
    end
    if (prod < ProdMin) begin
      prod = ProdMin;
    end
    return prod[ProdW-1:0];
  endfunction

  function automatic gate_up_item_t make_item(int g, int u, bit last, int idle);
    gate_up_item_t it;
    it.gate    = g[GateW-1:0];
    it.up      = u[UpW-1:0];
    it.row_end = last;
    it.idle    = idle;
    return it;
  endfunction

  // driver: one item per transfer, optional idle cycles ahead of each item
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic nxt;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      gate_i    <= '0;
      up_i      <= '0;
      row_end_i <= 1'b0;
      holding   = 1'b0;
      idle_left = 0;
    end else begin
      if (start_i && !busy_o) begin
        expected_outputs.push_back('{product: silu_times_up(cur.gate, cur.up),
                                     row_end: cur.row_end});
        n_accepted++;
        holding = 1'b0;
      end
      if (!holding && item_queue.size() > 0) begin
        cur       = item_queue.pop_front();
        idle_left = cur.idle;
        holding   = 1'b1;
      end
      if (holding && idle_left > 0) begin
        idle_left--;
        nxt = 1'b0;
      end else begin
        nxt = holding;
      end
      start_i <= nxt;
      // junk on the data ports while no transfer is offered
      gate_i    <= nxt ? cur.gate : GateW'($urandom);
      up_i      <= nxt ? cur.up : UpW'($urandom);
      row_end_i <= nxt ? cur.row_end : 1'($urandom);
    end
  end

  always @(posedge clk_i) begin : monitor
    swiglu_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result product=%0d row_end=%0b", $time, product_o,
                 row_end_out_o);
        n_errors++;
      end else begin
        want = expected_outputs.pop_front();
        if (product_o !== want.product) begin
          $display("%0t: product expected %0d actual %0d", $time, want.product, product_o);
          n_errors++;
        end
        if (row_end_out_o !== want.row_end) begin
          $display("%0t: row_end_out expected %0b actual %0b", $time, want.row_end,
                   row_end_out_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : main
    longint unsigned d;
    longint unsigned pos;
    longint unsigned mag;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    longint          acc;
    logic            neg;
    int              g;
    int              u;
    int              gap_max;
    int              row_left;

    // sigmoid samples over [-8, 8] in Q1.16, exp(-|x|) as Q2.30
    d = SIGMOID_TABLE_DEPTH;
    for (int k = 0; k <= SIGMOID_TABLE_DEPTH; k++) begin
      pos   = 16 * k;
      neg   = pos < 8 * d;
      mag   = neg ? 8 * d - pos : pos - 8 * d;
      whole = mag / d;
      frac  = ((mag % d) << 30) / d;
      acc   = longint'(OneQ30);
      term  = OneQ30;
      for (int n = 1; n <= TaylorTerms; n++) begin
        term = ((term * frac) >> 30) / longint'(n);
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      e = longint'(acc);
      for (longint unsigned n = 0; n < whole; n++) begin
        e = (e * ExpNeg1Q30 + (OneQ30 >> 1)) >> 30;
      end
      den = OneQ30 + e;
      if (neg) begin
        s = ((e << 16) + (den >> 1)) / den;
      end else begin
        s = ((64'd1 << 46) + (den >> 1)) / den;
      end
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      sig_tab[k] = s;
    end

    // directed: field extremes, zero, table edges, largest magnitude products
    item_queue.push_back(make_item(-32768, -32768, 1'b0, 0));
    item_queue.push_back(make_item(-32768, 32767, 1'b1, 0));
    item_queue.push_back(make_item(32767, 32767, 1'b0, 0));
    item_queue.push_back(make_item(32767, -32768, 1'b1, 1));
    item_queue.push_back(make_item(0, 32767, 1'b0, 0));
    item_queue.push_back(make_item(0, -32768, 1'b0, 0));
    item_queue.push_back(make_item(-1, -32768, 1'b1, 2));
    item_queue.push_back(make_item(1, 32767, 1'b0, 0));
    item_queue.push_back(make_item(-32768, 0, 1'b0, 0));
    item_queue.push_back(make_item(4096, 4096, 1'b1, 0));
    item_queue.push_back(make_item(-4096, 4096, 1'b0, 3));
    item_queue.push_back(make_item(256, -1, 1'b0, 0));
    item_queue.push_back(make_item(-256, 1, 1'b1, 0));
    item_queue.push_back(make_item(32512, 32767, 1'b0, 5));
    item_queue.push_back(make_item(-32513, -32768, 1'b0, 0));
    item_queue.push_back(make_item(255, 12345, 1'b1, 0));
    item_queue.push_back(make_item(-255, -12345, 1'b0, 0));
    item_queue.push_back(make_item(16384, -16384, 1'b1, 0));

    // random rows; every 40 items the sender picks anew between gaps and back-to-back
    gap_max  = 0;
    row_left = $urandom_range(1, 16);
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) begin
        gap_max = ($urandom_range(0, 1) == 1) ? 5 : 0;
      end
      case ($urandom_range(0, 3))
        0, 1: g = $urandom_range(0, 32767) - 16384;
        default: g = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: u = 32767;
        1: u = -32768;
        default: u = $urandom;
      endcase
      row_left--;
      item_queue.push_back(make_item(g, u, row_left == 0, $urandom_range(0, gap_max)));
      if (row_left == 0) begin
        row_left = $urandom_range(1, 16);
      end
    end
    n_items = item_queue.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_items || expected_outputs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
